[design/script_text_to_sjis_converter_unit_macros.svh]
// Assertion macros shared by the converter's checker.
`ifndef SCRIPT_TEXT_TO_SJIS_CONVERTER_UNIT_MACROS_SVH
`define SCRIPT_TEXT_TO_SJIS_CONVERTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STSC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("converter same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define STSC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("converter next-cycle check failed");

`endif

[design/stsc_pkg.sv]
// Shared types, constants and the half-width lookup table of the converter.
`timescale 1ns / 1ps
`default_nettype none

package stsc_pkg;

	// Expansion kinds handed from the front to the back
	typedef enum logic [2:0] {
		CMD_RAW,    // one byte as given
		CMD_ROM,    // table word, low byte then high byte
		CMD_DIGIT,  // full-width digit pair
		CMD_ESC,    // backslash, then the given byte
		CMD_NAME,   // backslash N A M E
		CMD_TEE     // backslash T
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  data;
		logic        last;
	} cmd_t;

	localparam logic [7:0]  DIGIT_LEAD = 8'h82;
	localparam logic [7:0]  DIGIT_BASE = 8'h4F;
	localparam logic [15:0] ROM_FILL   = 16'h2A2A;

	localparam logic [7:0]  CH_BSLASH  = 8'h5C;
	localparam logic [7:0]  CH_RBRACK  = 8'h5D;
	localparam logic [7:0]  CH_UC_C    = 8'h43;
	localparam logic [7:0]  CH_UC_K    = 8'h4B;
	localparam logic [7:0]  CH_LC_K    = 8'h6B;
	localparam logic [7:0]  CH_UC_N    = 8'h4E;
	localparam logic [7:0]  CH_LC_N    = 8'h6E;
	localparam logic [7:0]  CH_UC_A    = 8'h41;
	localparam logic [7:0]  CH_UC_M    = 8'h4D;
	localparam logic [7:0]  CH_UC_E    = 8'h45;
	localparam logic [7:0]  CH_UC_T    = 8'h54;
	localparam logic [7:0]  CH_ZERO    = 8'h30;
	localparam logic [7:0]  CH_NINE    = 8'h39;
	localparam logic [7:0]  CODE_TEE   = 8'h05;
	localparam logic [7:0]  CODE_NAME  = 8'h06;

	// Half-width to full-width table; unused codes give the star pair
	function automatic logic [15:0] rom_word(input logic [7:0] idx);
		logic [15:0] w;
		case (idx)
			8'h20: w = 16'h4F82; 8'h21: w = 16'h5082; 8'h22: w = 16'h5182; 8'h23: w = 16'h5282;
			8'h24: w = 16'h5382; 8'h26: w = 16'h5482; 8'h27: w = 16'h5582;
			8'h28: w = 16'h5682; 8'h29: w = 16'h5782; 8'h2A: w = 16'h5882; 8'h2B: w = 16'hA082;
			8'h2C: w = 16'hA282; 8'h2D: w = 16'hA482; 8'h2E: w = 16'hA682; 8'h2F: w = 16'hA882;
			8'h30: w = 16'hA982; 8'h31: w = 16'hAB82; 8'h32: w = 16'hAD82; 8'h33: w = 16'hAF82;
			8'h34: w = 16'hB182; 8'h35: w = 16'hB382; 8'h36: w = 16'hB582; 8'h37: w = 16'hB782;
			8'h38: w = 16'hB982; 8'h39: w = 16'hBB82; 8'h3A: w = 16'hBD82; 8'h3B: w = 16'hBF82;
			8'h3C: w = 16'hC282; 8'h3D: w = 16'hC482; 8'h3E: w = 16'hC682; 8'h3F: w = 16'hC882;
			8'h40: w = 16'hC982; 8'h41: w = 16'hCA82; 8'h42: w = 16'hCB82; 8'h43: w = 16'hCC82;
			8'h44: w = 16'hCD82; 8'h45: w = 16'hD082; 8'h46: w = 16'hD382; 8'h47: w = 16'hD682;
			8'h48: w = 16'hD982; 8'h49: w = 16'hDC82; 8'h4A: w = 16'hDD82; 8'h4B: w = 16'hDE82;
			8'h4C: w = 16'hDF82; 8'h4D: w = 16'hE082; 8'h4E: w = 16'hE282; 8'h4F: w = 16'hE482;
			8'h50: w = 16'hE682; 8'h51: w = 16'hE782; 8'h52: w = 16'hE882; 8'h53: w = 16'hE982;
			8'h54: w = 16'hEA82; 8'h55: w = 16'hEB82; 8'h56: w = 16'hED82; 8'h57: w = 16'hF082;
			8'h58: w = 16'hF182; 8'h59: w = 16'hAA82; 8'h5A: w = 16'hAC82; 8'h5B: w = 16'hAE82;
			8'h5D: w = 16'hB082; 8'h5E: w = 16'hB282; 8'h5F: w = 16'h6481;
			8'h60: w = 16'hB682; 8'h61: w = 16'hB882; 8'h62: w = 16'hBA82; 8'h63: w = 16'hBC82;
			8'h64: w = 16'hBE82; 8'h65: w = 16'hC082; 8'h66: w = 16'hCF82; 8'h67: w = 16'hC582;
			8'h68: w = 16'hC782; 8'h69: w = 16'hCE82; 8'h6A: w = 16'hD182; 8'h6B: w = 16'hD482;
			8'h6C: w = 16'hD782; 8'h6D: w = 16'hDA82; 8'h6E: w = 16'h9F82; 8'h6F: w = 16'hA182;
			8'h70: w = 16'hA382; 8'h71: w = 16'hA582; 8'h72: w = 16'hA782; 8'h73: w = 16'hE182;
			8'h74: w = 16'hE382; 8'h75: w = 16'hE582; 8'h76: w = 16'h4183; 8'h77: w = 16'h4383;
			8'h78: w = 16'h4583; 8'h79: w = 16'h4783; 8'h7A: w = 16'h4983; 8'h7B: w = 16'h4A83;
			8'h7C: w = 16'h4C83; 8'h7D: w = 16'h4E83; 8'h7E: w = 16'h5083; 8'h7F: w = 16'h5283;
			8'hA0: w = 16'h5483; 8'hA1: w = 16'h5683; 8'hA2: w = 16'h5883; 8'hA3: w = 16'h5A83;
			8'hA4: w = 16'h5C83; 8'hA5: w = 16'h5E83; 8'hA6: w = 16'h6083; 8'hA7: w = 16'h6383;
			8'hA8: w = 16'h6583; 8'hA9: w = 16'h6783; 8'hAA: w = 16'h6983; 8'hAB: w = 16'h6A83;
			8'hAC: w = 16'h6B83; 8'hAD: w = 16'h6C83; 8'hAE: w = 16'h6D83; 8'hAF: w = 16'h6E83;
			8'hB0: w = 16'h7183; 8'hB1: w = 16'h7483; 8'hB2: w = 16'h7783; 8'hB3: w = 16'h7A83;
			8'hB4: w = 16'h7D83; 8'hB5: w = 16'h7E83; 8'hB6: w = 16'h4281; 8'hB7: w = 16'h8183;
			8'hB8: w = 16'h8283; 8'hB9: w = 16'h8483; 8'hBA: w = 16'h8683; 8'hBB: w = 16'h8883;
			8'hBC: w = 16'h8983; 8'hBD: w = 16'h8A83; 8'hBE: w = 16'h8B83; 8'hBF: w = 16'h8C83;
			8'hC0: w = 16'h8D83; 8'hC1: w = 16'h8F83; 8'hC2: w = 16'h6081; 8'hC3: w = 16'h9383;
			8'hC4: w = 16'h4B83; 8'hC5: w = 16'h4D83; 8'hC6: w = 16'h4F83; 8'hC7: w = 16'h4981;
			8'hC8: w = 16'h5383; 8'hC9: w = 16'h5583; 8'hCA: w = 16'h5783; 8'hCB: w = 16'h5983;
			8'hCC: w = 16'h5B83; 8'hCD: w = 16'h5B81; 8'hCE: w = 16'h5F83; 8'hCF: w = 16'h6183;
			8'hD0: w = 16'h4181; 8'hD1: w = 16'h6683; 8'hD2: w = 16'h6883; 8'hD3: w = 16'h6F83;
			8'hD4: w = 16'h7283; 8'hD5: w = 16'h7583; 8'hD6: w = 16'h7883; 8'hD7: w = 16'h7B83;
			8'hD8: w = 16'h4083; 8'hD9: w = 16'h4283; 8'hDA: w = 16'h4881; 8'hDB: w = 16'h4683;
			8'hDC: w = 16'h4883; 8'hDD: w = 16'h8383; 8'hDE: w = 16'h8583; 8'hDF: w = 16'h8783;
			default: w = ROM_FILL;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

[design/stsc_fifo.sv]
// Short command queue between the parsing front and the expanding back.
`timescale 1ns / 1ps
`default_nettype none

module stsc_fifo #(
	parameter int DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire stsc_pkg::cmd_t wr_cmd,
	output logic               full,
	input  wire logic          rd_en,
	output logic               rd_valid,
	output stsc_pkg::cmd_t     rd_cmd
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	stsc_pkg::cmd_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_cmd   = mem_q[rd_ptr_q];

	// Store a request at the write pointer
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Advance pointers and track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[design/stsc_front.sv]
// Front end: accepts text bytes, tracks parse state, issues expansion commands.
`timescale 1ns / 1ps
`default_nettype none

module stsc_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic          full,
	input  wire logic [7:0]    text_byte,
	input  wire logic          text_last,
	output logic               cmd_push,
	output stsc_pkg::cmd_t     cmd
);

	typedef enum logic [2:0] {
		MODE_NORMAL,
		MODE_ESCAPE,
		MODE_COPY1,
		MODE_BRACKET,
		MODE_TRAIL
	} mode_t;

	mode_t mode_q, mode_d;
	logic  kana_q, kana_d;
	logic  digit_q, digit_d;
	logic  emit;
	logic  accept;
	logic  is_digit;
	logic  is_half;

	assign accept   = push && !full;
	assign is_digit = (text_byte >= stsc_pkg::CH_ZERO) && (text_byte <= stsc_pkg::CH_NINE);
	assign is_half  = !text_byte[7] || ((text_byte > 8'h9F) && (text_byte < 8'hE0));

	// Classify the byte and work out the next parse state
	always_comb begin
		mode_d   = mode_q;
		kana_d   = kana_q;
		digit_d  = digit_q;
		emit     = 1'b1;
		cmd.kind = stsc_pkg::CMD_RAW;
		cmd.data = text_byte;
		cmd.last = text_last;
		case (mode_q)
			MODE_ESCAPE: begin
				mode_d = MODE_NORMAL;
				cmd.kind = stsc_pkg::CMD_ESC;
				if (text_byte == stsc_pkg::CH_UC_C) begin
					mode_d = MODE_COPY1;
				end else if (text_byte == stsc_pkg::CH_UC_K) begin
					kana_d = 1'b0;
					emit = 1'b0;
				end else if (text_byte == stsc_pkg::CH_LC_K) begin
					kana_d = 1'b1;
					emit = 1'b0;
				end else if (text_byte == stsc_pkg::CH_UC_N) begin
					digit_d = 1'b1;
					emit = 1'b0;
				end else if (text_byte == stsc_pkg::CH_LC_N) begin
					digit_d = 1'b0;
					emit = 1'b0;
				end
			end
			MODE_COPY1, MODE_TRAIL: begin
				mode_d = MODE_NORMAL;
			end
			MODE_BRACKET: begin
				if (text_byte == stsc_pkg::CH_RBRACK) begin
					mode_d = MODE_NORMAL;
				end
			end
			default: begin
				mode_d = MODE_NORMAL;
				if (text_byte == stsc_pkg::CODE_TEE) begin
					cmd.kind = stsc_pkg::CMD_TEE;
					mode_d = MODE_BRACKET;
				end else if (text_byte == stsc_pkg::CODE_NAME) begin
					cmd.kind = stsc_pkg::CMD_NAME;
					mode_d = MODE_BRACKET;
				end else if (text_byte == stsc_pkg::CH_BSLASH) begin
					// lone backslash at string end goes out as is
					if (!text_last) begin
						emit = 1'b0;
						mode_d = MODE_ESCAPE;
					end
				end else if (is_digit && digit_q) begin
					cmd.kind = stsc_pkg::CMD_DIGIT;
				end else if (is_half) begin
					cmd.kind = kana_q ? stsc_pkg::CMD_RAW : stsc_pkg::CMD_ROM;
				end else begin
					mode_d = MODE_TRAIL;
				end
			end
		endcase
		// drop all modes at the end of a string
		if (text_last) begin
			mode_d  = MODE_NORMAL;
			kana_d  = 1'b0;
			digit_d = 1'b0;
		end
	end

	assign cmd_push = accept && emit;

	// Hold parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NORMAL;
			kana_q  <= 1'b0;
			digit_q <= 1'b0;
		end else if (accept) begin
			mode_q  <= mode_d;
			kana_q  <= kana_d;
			digit_q <= digit_d;
		end
	end

endmodule

`default_nettype wire

[design/stsc_back.sv]
// Back end: expands each command into output bytes, one per cycle unless held by pop.
`timescale 1ns / 1ps
`default_nettype none

module stsc_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	input  wire stsc_pkg::cmd_t cmd,
	output logic               cmd_pop,
	output logic               empty,
	input  wire logic          pop,
	output logic [7:0]         out_byte,
	output logic               run_last,
	output logic               string_end
);

	logic [2:0]  idx_q;
	logic [2:0]  last_idx;
	logic [7:0]  cur_byte;
	logic [15:0] word;
	logic        is_end;
	logic        advance;
	logic        out_valid_q;

	assign word = stsc_pkg::rom_word(cmd.data);

	// Select the byte at the current position of the expansion
	always_comb begin
		last_idx = 3'd1;
		cur_byte = cmd.data;
		case (cmd.kind)
			stsc_pkg::CMD_RAW: begin
				last_idx = 3'd0;
			end
			stsc_pkg::CMD_ROM: begin
				cur_byte = (idx_q == 3'd0) ? word[7:0] : word[15:8];
			end
			stsc_pkg::CMD_DIGIT: begin
				cur_byte = (idx_q == 3'd0) ? stsc_pkg::DIGIT_LEAD :
					stsc_pkg::DIGIT_BASE + {4'b0000, cmd.data[3:0]};
			end
			stsc_pkg::CMD_ESC: begin
				cur_byte = (idx_q == 3'd0) ? stsc_pkg::CH_BSLASH : cmd.data;
			end
			stsc_pkg::CMD_TEE: begin
				cur_byte = (idx_q == 3'd0) ? stsc_pkg::CH_BSLASH : stsc_pkg::CH_UC_T;
			end
			stsc_pkg::CMD_NAME: begin
				last_idx = 3'd4;
				case (idx_q)
					3'd0:    cur_byte = stsc_pkg::CH_BSLASH;
					3'd1:    cur_byte = stsc_pkg::CH_UC_N;
					3'd2:    cur_byte = stsc_pkg::CH_UC_A;
					3'd3:    cur_byte = stsc_pkg::CH_UC_M;
					default: cur_byte = stsc_pkg::CH_UC_E;
				endcase
			end
			default: begin
				last_idx = 3'd0;
			end
		endcase
	end

	assign is_end  = (idx_q == last_idx);
	assign advance = cmd_valid && (!out_valid_q || pop);
	assign cmd_pop = advance && is_end;
	assign empty   = !out_valid_q;

	// Advance the position and the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				idx_q       <= is_end ? 3'd0 : idx_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte   <= cur_byte;
			run_last   <= is_end;
			string_end <= is_end && cmd.last;
		end
	end

endmodule

`default_nettype wire

[design/script_text_to_sjis_converter_unit.sv]
// Top level of the script text to Shift-JIS converter.
`timescale 1ns / 1ps
`default_nettype none

// Script text bytes go in one per request on the push/full side and Shift-JIS
// bytes come out one per request on the empty/pop side. The front parses
// each byte in the cycle it is accepted and queues one command; bytes that
// only change modes (a plain backslash, the K, k, N and n escapes) queue
// nothing. The back emits exactly one output byte per cycle while its
// output register is empty or popped, so an input byte that expands to n
// results occupies the back for n bytes (1 for copied bytes, 2 for table,
// digit and escape pairs, 5 for the name prefix); sustained throughput is
// set by the back's one-byte-per-cycle output register. FIFO_DEPTH commands
// of slack let the input run ahead while results wait to be popped. The
// first result of a request goes through the FIFO, then the output register.
module script_text_to_sjis_converter_unit #(
	parameter int FIFO_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] text_byte,
	input  wire logic       text_last,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      out_byte,
	output logic            run_last,
	output logic            string_end
);

	stsc_pkg::cmd_t front_cmd;
	stsc_pkg::cmd_t head_cmd;
	logic           front_push;
	logic           head_valid;
	logic           head_pop;

	stsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.text_byte (text_byte),
		.text_last (text_last),
		.cmd_push  (front_push),
		.cmd       (front_cmd)
	);

	stsc_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (front_push),
		.wr_cmd   (front_cmd),
		.full     (full),
		.rd_en    (head_pop),
		.rd_valid (head_valid),
		.rd_cmd   (head_cmd)
	);

	stsc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (head_valid),
		.cmd        (head_cmd),
		.cmd_pop    (head_pop),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.string_end (string_end)
	);

endmodule

`default_nettype wire

[design/stsc_checker.sv]
// Port-level checker for the converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "script_text_to_sjis_converter_unit_macros.svh"

module stsc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       full,
	input wire logic       empty,
	input wire logic       pop,
	input wire logic [7:0] out_byte,
	input wire logic       run_last,
	input wire logic       string_end
);

	// End of string only on the final byte of an input's run
	`STSC_ASSERT_IMP(a_end_on_run_last, clk, arst_n, (!empty && string_end), run_last)

	// A run that is not finished keeps the output side busy
	`STSC_ASSERT_NXT(a_run_continues, clk, arst_n, (!empty && pop && !run_last), !empty)

	// A full queue always feeds the output register
	`STSC_ASSERT_NXT(a_full_feeds_out, clk, arst_n, full, !empty)

	// Hold a waiting result until it is taken
	`STSC_ASSERT_NXT(a_result_holds, clk, arst_n, (!empty && !pop), (!empty && $stable(out_byte) && $stable(run_last) && $stable(string_end)))

endmodule

bind script_text_to_sjis_converter_unit stsc_checker u_stsc_checker (.*);

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the script text to Shift-JIS converter.
`timescale 1ns / 1ps

module tb;

	localparam int RUN_LIMIT   = 300000;
	localparam int LONG_HOLD   = 120;
	localparam int HOLD_AFTER  = 45;
	localparam int BATCH_BYTES = 40;

	// Byte ranges that select table lookup versus lead-byte copy
	localparam logic [7:0] HALF_LO_END   = 8'h80;
	localparam logic [7:0] LEAD_HI_LAST  = 8'h9F;
	localparam logic [7:0] KANA_HI_START = 8'hE0;

	// Parser states of the prediction
	typedef enum logic [2:0] {
		SCAN_PLAIN,
		SCAN_ESCAPE,
		SCAN_COPY_ONE,
		SCAN_NAME_ARG,
		SCAN_TRAIL
	} scan_mode_t;

	typedef struct {
		logic [7:0] data;
		logic       fin;
	} text_req_t;

	typedef struct {
		logic [7:0] value;
		logic       run_end;
		logic       str_end;
	} sjis_byte_t;

	// Full-width words for half-width codes, low byte first on the wire
	localparam logic [15:0] WIDE_FORM [0:223] = '{
		16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A,
		16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A,
		16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A,
		16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A,
		16'h4F82, 16'h5082, 16'h5182, 16'h5282, 16'h5382, 16'h2A2A, 16'h5482, 16'h5582,
		16'h5682, 16'h5782, 16'h5882, 16'hA082, 16'hA282, 16'hA482, 16'hA682, 16'hA882,
		16'hA982, 16'hAB82, 16'hAD82, 16'hAF82, 16'hB182, 16'hB382, 16'hB582, 16'hB782,
		16'hB982, 16'hBB82, 16'hBD82, 16'hBF82, 16'hC282, 16'hC482, 16'hC682, 16'hC882,
		16'hC982, 16'hCA82, 16'hCB82, 16'hCC82, 16'hCD82, 16'hD082, 16'hD382, 16'hD682,
		16'hD982, 16'hDC82, 16'hDD82, 16'hDE82, 16'hDF82, 16'hE082, 16'hE282, 16'hE482,
		16'hE682, 16'hE782, 16'hE882, 16'hE982, 16'hEA82, 16'hEB82, 16'hED82, 16'hF082,
		16'hF182, 16'hAA82, 16'hAC82, 16'hAE82, 16'h2A2A, 16'hB082, 16'hB282, 16'h6481,
		16'hB682, 16'hB882, 16'hBA82, 16'hBC82, 16'hBE82, 16'hC082, 16'hCF82, 16'hC582,
		16'hC782, 16'hCE82, 16'hD182, 16'hD482, 16'hD782, 16'hDA82, 16'h9F82, 16'hA182,
		16'hA382, 16'hA582, 16'hA782, 16'hE182, 16'hE382, 16'hE582, 16'h4183, 16'h4383,
		16'h4583, 16'h4783, 16'h4983, 16'h4A83, 16'h4C83, 16'h4E83, 16'h5083, 16'h5283,
		16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A,
		16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A,
		16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A,
		16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A, 16'h2A2A,
		16'h5483, 16'h5683, 16'h5883, 16'h5A83, 16'h5C83, 16'h5E83, 16'h6083, 16'h6383,
		16'h6583, 16'h6783, 16'h6983, 16'h6A83, 16'h6B83, 16'h6C83, 16'h6D83, 16'h6E83,
		16'h7183, 16'h7483, 16'h7783, 16'h7A83, 16'h7D83, 16'h7E83, 16'h4281, 16'h8183,
		16'h8283, 16'h8483, 16'h8683, 16'h8883, 16'h8983, 16'h8A83, 16'h8B83, 16'h8C83,
		16'h8D83, 16'h8F83, 16'h6081, 16'h9383, 16'h4B83, 16'h4D83, 16'h4F83, 16'h4981,
		16'h5383, 16'h5583, 16'h5783, 16'h5983, 16'h5B83, 16'h5B81, 16'h5F83, 16'h6183,
		16'h4181, 16'h6683, 16'h6883, 16'h6F83, 16'h7283, 16'h7583, 16'h7883, 16'h7B83,
		16'h4083, 16'h4283, 16'h4881, 16'h4683, 16'h4883, 16'h8383, 16'h8583, 16'h8783
	};

	// Opening strings: {last, byte}
	localparam logic [8:0] OPENING [0:27] = '{
		{1'b0, 8'h00}, {1'b0, 8'h80}, {1'b0, 8'h7F}, {1'b1, 8'hE0},
		{1'b1, stsc_pkg::CH_BSLASH},
		{1'b0, stsc_pkg::CH_BSLASH}, {1'b0, stsc_pkg::CH_LC_K}, {1'b0, 8'hA5},
		{1'b0, stsc_pkg::CH_BSLASH}, {1'b0, stsc_pkg::CH_UC_K}, {1'b0, 8'hDF},
		{1'b0, stsc_pkg::CH_BSLASH}, {1'b0, stsc_pkg::CH_UC_N}, {1'b0, stsc_pkg::CH_NINE},
		{1'b0, stsc_pkg::CH_BSLASH}, {1'b0, stsc_pkg::CH_UC_C}, {1'b1, stsc_pkg::CODE_NAME},
		{1'b0, stsc_pkg::CH_BSLASH}, {1'b1, stsc_pkg::CH_UC_C},
		{1'b0, stsc_pkg::CODE_NAME}, {1'b0, stsc_pkg::CH_RBRACK},
		{1'b0, stsc_pkg::CODE_TEE}, {1'b0, 8'hFF}, {1'b0, stsc_pkg::CH_RBRACK},
		{1'b0, stsc_pkg::CH_BSLASH}, {1'b0, 8'h7A},
		{1'b0, stsc_pkg::CH_BSLASH}, {1'b1, stsc_pkg::CH_LC_N}
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] text_byte;
	logic       text_last;
	logic       empty;
	logic       pop;
	logic [7:0] out_byte;
	logic       run_last;
	logic       string_end;

	text_req_t  text_feed[$];
	sjis_byte_t sjis_expected[$];

	scan_mode_t scan_mode;
	logic       kana_on;
	logic       digit_on;

	int  send_idle_pct;
	int  recv_idle_pct;
	int  bytes_fed;
	int  bytes_in;
	int  bytes_out;
	int  strings_done;
	int  full_cycles;
	int  errors;
	int  cycle_count;
	int  hold_left;
	bit  hold_used;
	bit  byte_taken;

	script_text_to_sjis_converter_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.text_byte (text_byte),
		.text_last (text_last),
		.empty     (empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.string_end(string_end)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
	end

	function automatic void add_out(input logic [7:0] b);
		sjis_byte_t s;
		s.value   = b;
		s.run_end = 1'b0;
		s.str_end = 1'b0;
		sjis_expected.insert(sjis_expected.size(), s);
	endfunction

	// Predict the output bytes of one accepted text byte
	function automatic void convert_byte(input logic [7:0] c, input logic fin);
		int          base;
		logic [15:0] w;
		base = sjis_expected.size();
		case (scan_mode)
			SCAN_ESCAPE: begin
				scan_mode = SCAN_PLAIN;
				if (c == stsc_pkg::CH_UC_C) begin
					add_out(stsc_pkg::CH_BSLASH);
					add_out(stsc_pkg::CH_UC_C);
					scan_mode = SCAN_COPY_ONE;
				end else if (c == stsc_pkg::CH_UC_K) begin
					kana_on = 1'b0;
				end else if (c == stsc_pkg::CH_LC_K) begin
					kana_on = 1'b1;
				end else if (c == stsc_pkg::CH_UC_N) begin
					digit_on = 1'b1;
				end else if (c == stsc_pkg::CH_LC_N) begin
					digit_on = 1'b0;
				end else begin
					add_out(stsc_pkg::CH_BSLASH);
					add_out(c);
				end
			end
			SCAN_COPY_ONE, SCAN_TRAIL: begin
				add_out(c);
				scan_mode = SCAN_PLAIN;
			end
			SCAN_NAME_ARG: begin
				add_out(c);
				if (c == stsc_pkg::CH_RBRACK) begin
					scan_mode = SCAN_PLAIN;
				end
			end
			default: begin
				scan_mode = SCAN_PLAIN;
				if (c == stsc_pkg::CODE_TEE || c == stsc_pkg::CODE_NAME) begin
					add_out(stsc_pkg::CH_BSLASH);
					if (c == stsc_pkg::CODE_NAME) begin
						add_out(stsc_pkg::CH_UC_N);
						add_out(stsc_pkg::CH_UC_A);
						add_out(stsc_pkg::CH_UC_M);
						add_out(stsc_pkg::CH_UC_E);
					end else begin
						add_out(stsc_pkg::CH_UC_T);
					end
					scan_mode = SCAN_NAME_ARG;
				end else if (c == stsc_pkg::CH_BSLASH) begin
					if (fin) begin
						add_out(stsc_pkg::CH_BSLASH);
					end else begin
						scan_mode = SCAN_ESCAPE;
					end
				end else if (c >= stsc_pkg::CH_ZERO && c <= stsc_pkg::CH_NINE
						&& digit_on) begin
					add_out(stsc_pkg::DIGIT_LEAD);
					add_out(stsc_pkg::DIGIT_BASE + (c - stsc_pkg::CH_ZERO));
				end else if (c < HALF_LO_END || (c > LEAD_HI_LAST && c < KANA_HI_START)) begin
					if (kana_on) begin
						add_out(c);
					end else begin
						w = WIDE_FORM[c];
						add_out(w[7:0]);
						add_out(w[15:8]);
					end
				end else begin
					add_out(c);
					scan_mode = SCAN_TRAIL;
				end
			end
		endcase
		// Flag the final byte of this run, and of the string on the last byte
		if (sjis_expected.size() > base) begin
			sjis_expected[sjis_expected.size() - 1].run_end = 1'b1;
			sjis_expected[sjis_expected.size() - 1].str_end = fin;
		end
		if (fin) begin
			scan_mode = SCAN_PLAIN;
			kana_on   = 1'b0;
			digit_on  = 1'b0;
		end
	endfunction

	task automatic queue_byte(input logic [7:0] b, input logic fin);
		text_req_t r;
		r.data = b;
		r.fin  = fin;
		text_feed.insert(text_feed.size(), r);
		bytes_fed++;
	endtask

	// Build one string from well-formed pieces, with some noise and cut endings
	task automatic queue_random_string();
		logic [7:0] seq[$];
		logic [7:0] b;
		int         pieces;
		int         i;
		pieces = $urandom_range(1, 6);
		repeat (pieces) begin
			case ($urandom_range(0, 11))
				0, 1, 2: begin
					b = 8'($urandom_range(0, 127));
					if (b == stsc_pkg::CODE_TEE || b == stsc_pkg::CODE_NAME
							|| b == stsc_pkg::CH_BSLASH) begin
						b = stsc_pkg::CH_UC_A;
					end
					seq.insert(seq.size(), b);
				end
				3: seq.insert(seq.size(), 8'($urandom_range(8'hA0, 8'hDF)));
				4: seq.insert(seq.size(),
					8'($urandom_range(stsc_pkg::CH_ZERO, stsc_pkg::CH_NINE)));
				5: begin
					if ($urandom_range(0, 1) == 0) begin
						seq.insert(seq.size(), 8'($urandom_range(8'h80, 8'h9F)));
					end else begin
						seq.insert(seq.size(), 8'($urandom_range(8'hE0, 8'hFF)));
					end
					seq.insert(seq.size(), 8'($urandom));
				end
				6: begin
					seq.insert(seq.size(), stsc_pkg::CH_BSLASH);
					case ($urandom_range(0, 3))
						0: seq.insert(seq.size(), stsc_pkg::CH_UC_K);
						1: seq.insert(seq.size(), stsc_pkg::CH_LC_K);
						2: seq.insert(seq.size(), stsc_pkg::CH_UC_N);
						default: seq.insert(seq.size(), stsc_pkg::CH_LC_N);
					endcase
				end
				7: begin
					seq.insert(seq.size(), stsc_pkg::CH_BSLASH);
					seq.insert(seq.size(), stsc_pkg::CH_UC_C);
					seq.insert(seq.size(), 8'($urandom));
				end
				8: begin
					seq.insert(seq.size(), stsc_pkg::CH_BSLASH);
					seq.insert(seq.size(), 8'($urandom));
				end
				9: begin
					seq.insert(seq.size(),
						$urandom_range(0, 1) ? stsc_pkg::CODE_NAME : stsc_pkg::CODE_TEE);
					repeat ($urandom_range(0, 3)) begin
						b = 8'($urandom);
						if (b == stsc_pkg::CH_RBRACK) begin
							b = stsc_pkg::CH_UC_A;
						end
						seq.insert(seq.size(), b);
					end
					seq.insert(seq.size(), stsc_pkg::CH_RBRACK);
				end
				default: seq.insert(seq.size(), 8'($urandom));
			endcase
		end
		// Cut the last piece short now and then
		if (seq.size() > 1 && $urandom_range(0, 5) == 0) begin
			void'(seq.pop_back());
		end
		for (i = 0; i < seq.size(); i++) begin
			queue_byte(seq[i], i == seq.size() - 1);
		end
	endtask

	task automatic wait_drained();
		while (bytes_in != bytes_fed || sjis_expected.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Offer requests; hold the current one until it is taken
	always @(negedge clk) begin
		text_req_t req;
		if (arst_n) begin
			if (!push || byte_taken) begin
				if (text_feed.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					req = text_feed.pop_front();
					push      <= 1'b1;
					text_byte <= req.data;
					text_last <= req.fin;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Drain results, with one long hold once the stream is going
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_used && bytes_in >= HOLD_AFTER) begin
				hold_used = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Check results against the oldest prediction; predict accepted requests
	always @(posedge clk) begin
		sjis_byte_t want;
		byte_taken = 1'b0;
		if (arst_n) begin
			if (full) begin
				full_cycles++;
			end
			if (pop && !empty) begin
				bytes_out++;
				if (string_end) begin
					strings_done++;
				end
				if (sjis_expected.size() == 0) begin
					$display("%0t: result with none expected: out_byte=%02h run_last=%0b string_end=%0b",
						$time, out_byte, run_last, string_end);
					errors++;
				end else begin
					want = sjis_expected.pop_front();
					if (out_byte !== want.value || run_last !== want.run_end
							|| string_end !== want.str_end) begin
						$display("%0t: expected out_byte=%02h run_last=%0b string_end=%0b, got %02h %0b %0b",
							$time, want.value, want.run_end, want.str_end,
							out_byte, run_last, string_end);
						errors++;
					end
				end
			end
			if (push && !full) begin
				byte_taken = 1'b1;
				bytes_in++;
				convert_byte(text_byte, text_last);
			end
		end
	end

	initial begin
		wait (cycle_count >= RUN_LIMIT);
		$display("timeout after %0d cycles, %0d results still expected",
			cycle_count, sjis_expected.size());
		$display("simulation failed");
		$finish;
	end

	initial begin
		int i;
		int target;
		int phase;
		arst_n    = 1'b0;
		push      = 1'b0;
		pop       = 1'b0;
		text_byte = 8'h00;
		text_last = 1'b0;
		scan_mode = SCAN_PLAIN;
		kana_on   = 1'b0;
		digit_on  = 1'b0;
		send_idle_pct = 19;
		recv_idle_pct = 58;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Directed strings: extremes, every escape and each cut ending
		for (i = 0; i < $size(OPENING); i++) begin
			queue_byte(OPENING[i][7:0], OPENING[i][8]);
		end

		// Random strings under three idle patterns, draining between them
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 19;
					recv_idle_pct = 58;
				end
				1: begin
					send_idle_pct = 58;
					recv_idle_pct = 19;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			target = bytes_fed + BATCH_BYTES;
			while (bytes_fed < target) begin
				queue_random_string();
			end
			wait_drained();
			repeat (8) @(negedge clk);
		end

		wait_drained();
		repeat (10) @(negedge clk);
		$display("%0d text bytes in, %0d Shift-JIS bytes out, %0d strings closed",
			bytes_in, bytes_out, strings_done);
		$display("input held off on %0d cycles, %0d mismatches", full_cycles, errors);
		if (errors == 0 && sjis_expected.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
